@@ hdl/line_anchor_indexer_unit_macros.svh @@
// Assertion macros shared by the line anchor indexer RTL.
`ifndef LINE_ANCHOR_INDEXER_UNIT_MACROS_SVH
`define LINE_ANCHOR_INDEXER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LAI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LAI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/lai_pkg.sv @@
// Types and constants for the line anchor indexer.
package lai_pkg;

   localparam int unsigned VALUE_BITS     = 48;
   localparam int unsigned WIDE_BITS      = 64;
   localparam int unsigned GRAN_BITS      = 16;
   localparam int unsigned CSR_DATA_BITS  = 32;
   localparam int unsigned CSR_ADDR_BITS  = 3;
   localparam int unsigned RBUF_DEPTH     = 4;
   localparam int unsigned RBUF_PTR_BITS  = 2;
   localparam int unsigned RBUF_CNT_BITS  = 3;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   // Word index of each register (upper address bit)
   typedef enum logic [0:0] {
      CSR_REG_GRANULARITY = 1'b0
   } csr_reg_type;

   // Kind of a result
   typedef enum logic [0:0] {
      KIND_ANCHOR = 1'b0,
      KIND_COUNT  = 1'b1
   } result_kind_type;

   typedef struct packed {
      logic                  result_kind;
      logic [VALUE_BITS-1:0] result_value;
      logic                  last_of_run;
   } result_type;

   // Results produced by one request, written to the buffer together
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   typedef struct packed {
      logic fire;
      logic fire_eof;
      logic pending;
      logic pos_zero;
   } core_status_type;

   typedef struct packed {
      logic [RBUF_CNT_BITS-1:0] count;
      logic                     room;
      logic                     pop;
   } rbuf_status_type;

endpackage

@@ hdl/lai_req_if.sv @@
// Request channel: one file byte with its flags.
interface lai_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_file;

   modport source (output valid, data_byte, byte_present, end_of_file, input ready);
   modport sink (input valid, data_byte, byte_present, end_of_file, output ready);
endinterface

@@ hdl/lai_rsp_if.sv @@
// Result channel: anchor offsets and line counts.
interface lai_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [47:0] result_value;
   logic        last_of_run;

   modport source (output valid, result_kind, result_value, last_of_run, input ready);
   modport sink (input valid, result_kind, result_value, last_of_run, output ready);
endinterface

@@ hdl/lai_csr.sv @@
// APB-style register block holding the anchor granularity.
module lai_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lai_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [lai_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [lai_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready,
   output logic [lai_pkg::GRAN_BITS-1:0]      granularity
);
   import lai_pkg::*;

   logic [GRAN_BITS-1:0] gran_ff;
   logic                 hit;
   logic                 wr_en;

   // Decode the word index
   assign hit        = (csr_paddr[CSR_ADDR_BITS-1] == CSR_REG_GRANULARITY);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && hit;
   assign csr_pready = 1'b1;

   // Hold the register
   always_ff @(posedge clock) begin
      if (reset) begin
         gran_ff <= GRAN_BITS'(1);
      end else if (wr_en) begin
         gran_ff <= csr_pwdata[GRAN_BITS-1:0];
      end
   end

   // Return the register on reads
   assign csr_prdata  = hit ? CSR_DATA_BITS'(gran_ff) : '0;
   assign granularity = gran_ff;
endmodule

@@ hdl/lai_core.sv @@
// Input register, per-file counters and result formation.
module lai_core #(
   parameter int unsigned OFFSET_BITS = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   lai_req_if.sink                       req_bus,
   input  logic [lai_pkg::GRAN_BITS-1:0] granularity,
   input  logic                          room,
   output lai_pkg::push_type             push,
   output lai_pkg::core_status_type      status
);
   import lai_pkg::*;

   // Input register
   logic                   stage_valid_ff;
   logic [7:0]             stage_data_ff;
   logic                   stage_present_ff;
   logic                   stage_eof_ff;

   // Per-file state
   logic [OFFSET_BITS-1:0] pos_ff, pos_in, pos_inc;
   logic [OFFSET_BITS-1:0] nl_ff, nl_in, nl_inc;
   logic [GRAN_BITS-1:0]   lua_ff, lua_in;
   logic                   pending_ff, pending_in;
   logic                   prev_ff, prev_in;

   logic                   fire;
   logic                   req_ready;
   logic                   is_nl;
   logic                   anchor;
   logic                   reach;
   logic                   bump;
   logic [GRAN_BITS-1:0]   gran_eff;
   logic [GRAN_BITS:0]     lua_next;
   logic [OFFSET_BITS-1:0] total;
   logic [WIDE_BITS-1:0]   pos_wide, total_wide;
   result_type             anchor_res, count_res;

   assign fire          = stage_valid_ff && room;
   assign req_ready     = !stage_valid_ff || fire;
   assign req_bus.ready = req_ready;

   // Load the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_ready) begin
         stage_data_ff    <= req_bus.data_byte;
         stage_present_ff <= req_bus.byte_present;
         stage_eof_ff     <= req_bus.end_of_file;
      end
   end

   // Compute next state and results
   always_comb begin
      is_nl    = stage_present_ff && (stage_data_ff == NEWLINE_CODE);
      anchor   = stage_present_ff && pending_ff;
      pos_inc  = (pos_ff == '1) ? pos_ff : pos_ff + OFFSET_BITS'(1);
      nl_inc   = (nl_ff == '1) ? nl_ff : nl_ff + OFFSET_BITS'(1);
      gran_eff = (granularity == '0) ? GRAN_BITS'(1) : granularity;
      lua_next = (GRAN_BITS+1)'(lua_ff) + (GRAN_BITS+1)'(1);
      reach    = lua_next >= (GRAN_BITS+1)'(gran_eff);

      pos_in     = stage_present_ff ? pos_inc : pos_ff;
      nl_in      = is_nl ? nl_inc : nl_ff;
      pending_in = (pending_ff && !stage_present_ff) || (is_nl && reach);
      if (is_nl) begin
         lua_in = reach ? '0 : lua_next[GRAN_BITS-1:0];
      end else begin
         lua_in = lua_ff;
      end
      prev_in = stage_present_ff ? is_nl : prev_ff;

      // Count one more line when the file ends without a newline;
      // a newline in this request is already part of the count
      bump  = stage_present_ff ? !is_nl : (!prev_ff && (pos_ff != '0));
      total = (bump || is_nl) ? nl_inc : nl_ff;

      pos_wide   = WIDE_BITS'(pos_ff);
      total_wide = WIDE_BITS'(total);

      anchor_res.result_kind  = KIND_ANCHOR;
      anchor_res.result_value = pos_wide[VALUE_BITS-1:0];
      anchor_res.last_of_run  = !stage_eof_ff;

      count_res.result_kind  = KIND_COUNT;
      count_res.result_value = total_wide[VALUE_BITS-1:0];
      count_res.last_of_run  = 1'b1;

      push.count  = fire ? (2'(anchor) + 2'(stage_eof_ff)) : 2'd0;
      push.first  = anchor ? anchor_res : count_res;
      push.second = count_res;
   end

   // Advance the file state; clear it after the end of a file
   always_ff @(posedge clock) begin
      if (reset || (fire && stage_eof_ff)) begin
         pos_ff     <= '0;
         nl_ff      <= '0;
         lua_ff     <= '0;
         pending_ff <= 1'b1;
         prev_ff    <= 1'b0;
      end else if (fire) begin
         pos_ff     <= pos_in;
         nl_ff      <= nl_in;
         lua_ff     <= lua_in;
         pending_ff <= pending_in;
         prev_ff    <= prev_in;
      end
   end

   assign status.fire     = fire;
   assign status.fire_eof = fire && stage_eof_ff;
   assign status.pending  = pending_ff;
   assign status.pos_zero = (pos_ff == '0);
endmodule

@@ hdl/lai_rbuf.sv @@
// Result buffer: takes up to two results a cycle, sends one a cycle while rsp is ready.
module lai_rbuf (
   input  logic                     clock,
   input  logic                     reset,
   input  lai_pkg::push_type        push,
   lai_rsp_if.source                rsp_bus,
   output lai_pkg::rbuf_status_type status
);
   import lai_pkg::*;

   result_type               entries [RBUF_DEPTH];
   logic [RBUF_PTR_BITS-1:0] wr_ptr_ff;
   logic [RBUF_PTR_BITS-1:0] rd_ptr_ff;
   logic [RBUF_CNT_BITS-1:0] count_ff;
   logic                     pop;
   result_type               head;

   assign pop = rsp_bus.valid && rsp_bus.ready;

   // Write the new results
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries[wr_ptr_ff + RBUF_PTR_BITS'(1)] <= push.second;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + RBUF_PTR_BITS'(push.count);
         rd_ptr_ff <= rd_ptr_ff + RBUF_PTR_BITS'(pop);
         count_ff  <= count_ff + RBUF_CNT_BITS'(push.count) - RBUF_CNT_BITS'(pop);
      end
   end

   // Drive the head entry
   assign head                 = entries[rd_ptr_ff];
   assign rsp_bus.valid        = (count_ff != '0);
   assign rsp_bus.result_kind  = head.result_kind;
   assign rsp_bus.result_value = head.result_value;
   assign rsp_bus.last_of_run  = head.last_of_run;

   assign status.count = count_ff;
   assign status.room  = (count_ff <= RBUF_CNT_BITS'(RBUF_DEPTH - 2));
   assign status.pop   = pop;
endmodule

@@ hdl/line_anchor_indexer_unit.sv @@
// A request's first result reaches rsp through the input register and then the result buffer.
// The input register takes one request per cycle while the buffer has room; the buffer drains
// one result per cycle while rsp is ready, so a request giving both an anchor and the count yields two.
// Reset clears all per-file counters, arms the anchor for line one, sets granularity
// to one and empties the result buffer.
`include "line_anchor_indexer_unit_macros.svh"
module line_anchor_indexer_unit #(
   parameter int unsigned OFFSET_BITS = 48
) (
   input  logic                               clock,
   input  logic                               reset,
   lai_req_if.sink                            req_bus,
   lai_rsp_if.source                          rsp_bus,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lai_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [lai_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [lai_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import lai_pkg::*;

   logic [GRAN_BITS-1:0]     granularity;
   push_type                 push;
   core_status_type          core_status;
   rbuf_status_type          rbuf_status;
   logic                     buf_in_bound;
   logic                     file_rearmed;
   logic [RBUF_CNT_BITS:0]   occ_wide;
   logic [RBUF_CNT_BITS:0]   occ_next;

   lai_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .granularity (granularity)
   );

   lai_core #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .granularity (granularity),
      .room        (rbuf_status.room),
      .push        (push),
      .status      (core_status)
   );

   lai_rbuf u_rbuf (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .rsp_bus (rsp_bus),
      .status  (rbuf_status)
   );

   // Terms checked by the assertions
   assign buf_in_bound = (rbuf_status.count <= RBUF_CNT_BITS'(RBUF_DEPTH));
   assign file_rearmed = core_status.pending && core_status.pos_zero;
   assign occ_wide     = (RBUF_CNT_BITS+1)'(rbuf_status.count);
   assign occ_next     = occ_wide + (RBUF_CNT_BITS+1)'(push.count)
                         - (RBUF_CNT_BITS+1)'(rbuf_status.pop);

   // Buffer never overfills
   `LAI_ASSERT_IMP(a_rbuf_bound, clock, reset, 1'b1, buf_in_bound, "result buffer over capacity")
   // Occupancy follows pushes and pops
   `LAI_ASSERT_NEXT(a_rbuf_track, clock, reset, 1'b1, (occ_wide == $past(occ_next)), "count drift")
   // End of file rearms the counters
   `LAI_ASSERT_NEXT(a_eof_clear, clock, reset, core_status.fire_eof, file_rearmed, "state not cleared")
endmodule
